// File: rtl/pvid_pkg.sv
package pvid_pkg;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_FORMAT_SELECT = 1'b0;  // register index, taken from paddr[2]

  typedef enum logic [1:0] {
    FMT_FIXED32  = 2'd0,
    FMT_VARINT32 = 2'd1,
    FMT_FIXED64  = 2'd2,
    FMT_VARINT64 = 2'd3
  } fmt_e;

  localparam fmt_e FMT_RESET = FMT_VARINT32;

  // Body layout of a pending value
  typedef enum logic [1:0] {
    KIND_FOUR  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_TWO   = 2'd2,
    KIND_THREE = 2'd3
  } kind_e;

  // Lead byte fields
  localparam logic [1:0] LEAD_PREFIX = 2'b10;
  localparam logic [1:0] LEN_ONE     = 2'd0;
  localparam logic [1:0] LEN_TWO     = 2'd1;
  localparam logic [1:0] LEN_THREE   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] decoded_value;
    logic               was_truncated;
  } out_item_t;

  typedef struct packed {
    logic [31:0] accumulator;
    logic [2:0]  bytes_needed;
    kind_e       code_kind;
    logic [31:0] high_half;
    logic        on_second_half;
  } dec_state_t;

  localparam dec_state_t DEC_IDLE = '{
    accumulator:    32'd0,
    bytes_needed:   3'd0,
    code_kind:      KIND_FOUR,
    high_half:      32'd0,
    on_second_half: 1'b0
  };

endpackage

// File: rtl/pvid_step.sv
module pvid_step (
  input  pvid_pkg::fmt_e       fmt_i,
  input  pvid_pkg::dec_state_t state_i,
  input  pvid_pkg::in_item_t   item_i,
  output pvid_pkg::dec_state_t state_o,
  output logic                 emit_o,
  output pvid_pkg::out_item_t  result_o
);
  import pvid_pkg::*;

  logic        done;
  logic        cut;
  logic [31:0] value;
  logic [31:0] acc_base;
  logic [2:0]  need_base;
  logic [2:0]  need_left;
  logic [31:0] acc_shift;
  logic [31:0] nibble;
  logic [7:0]  byte_in;
  dec_state_t  body;

  assign byte_in   = item_i.data_byte;
  assign nibble    = {{28{byte_in[3]}}, byte_in[3:0]};
  // A fresh fixed-format value starts its four-byte body with this byte
  assign acc_base  = (state_i.bytes_needed == 3'd0) ? 32'd0 : state_i.accumulator;
  assign need_base = (state_i.bytes_needed == 3'd0) ? 3'd4 : state_i.bytes_needed;
  assign acc_shift = {acc_base[23:0], byte_in};
  assign need_left = need_base - 3'd1;

  // Consume one transaction: update the body, flag a finished 32-bit value
  always_comb begin
    body  = state_i;
    done  = 1'b0;
    cut   = 1'b0;
    value = 32'd0;
    if (item_i.end_of_buffer) begin
      if (state_i.bytes_needed != 3'd0 || state_i.on_second_half) begin
        done = 1'b1;
        cut  = 1'b1;
        if (state_i.bytes_needed != 3'd0 && state_i.code_kind == KIND_ONE) begin
          value = {state_i.accumulator[23:0], 8'd0};
        end
      end
    end else if (state_i.bytes_needed == 3'd0 && fmt_i[0]) begin
      if (byte_in[7:6] != LEAD_PREFIX) begin
        done  = 1'b1;
        value = {{24{byte_in[7]}}, byte_in};
      end else begin
        case (byte_in[5:4])
          LEN_ONE: begin
            body.code_kind    = KIND_ONE;
            body.bytes_needed = 3'd1;
            body.accumulator  = nibble;
          end
          LEN_TWO: begin
            body.code_kind    = KIND_TWO;
            body.bytes_needed = 3'd2;
            body.accumulator  = nibble;
          end
          LEN_THREE: begin
            body.code_kind    = KIND_THREE;
            body.bytes_needed = 3'd3;
            body.accumulator  = nibble;
          end
          default: begin
            body.code_kind    = KIND_FOUR;
            body.bytes_needed = 3'd4;
            body.accumulator  = 32'd0;
          end
        endcase
      end
    end else begin
      if (state_i.bytes_needed == 3'd0) begin
        body.code_kind = KIND_FOUR;
      end
      body.accumulator  = acc_shift;
      body.bytes_needed = need_left;
      if (need_left == 3'd0) begin
        done  = 1'b1;
        value = acc_shift;
      end
    end
  end

  // Finish a value: emit it, or hold it as the high half of a 64-bit one
  always_comb begin
    state_o  = body;
    emit_o   = 1'b0;
    result_o = '{decoded_value: 64'sd0, was_truncated: 1'b0};
    if (done) begin
      state_o                = DEC_IDLE;
      emit_o                 = 1'b1;
      result_o.was_truncated = cut;
      if (!fmt_i[1]) begin
        result_o.decoded_value = {{32{value[31]}}, value};
      end else if (!state_i.on_second_half) begin
        if (!cut) begin
          emit_o                 = 1'b0;
          state_o.high_half      = value;
          state_o.on_second_half = 1'b1;
        end else begin
          result_o.decoded_value = {value, 32'd0};
        end
      end else begin
        result_o.decoded_value = {state_i.high_half, value};
      end
    end
  end

endmodule

// File: rtl/prefix_varint_integer_decoder_core.sv
// Prefix-varint integer decoder.
// Input channel: one byte per transaction (in_valid_i / in_stall_o, payload
// in_data_i); end_of_buffer cuts a pending value short and carries no byte.
// Output channel: one decoded 64-bit signed value per finished integer
// (out_valid_o / out_stall_i, payload out_data_o), with a truncation flag.
// Configuration: APB-style port, format_select at byte address 0. Write it
// only while the block is idle; a write drops any partly decoded value.
// Latency: a result appears on out_valid_o the cycle after the transaction
// holding its last byte (or the end-of-buffer marker) is taken.
// Throughput: one byte per cycle while in_stall_o is low; each byte goes
// through one pass of the step logic between the state and output registers.
// A stalled result stays in the output register; a new transaction is taken
// alongside it only once the receiver takes it, so in_stall_o follows
// out_stall_i while a result waits.
// Reset: decoder idle, output empty, format_select = varint 32-bit.
module prefix_varint_integer_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pvid_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pvid_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvid_pkg::PADDR_W-1:0]  paddr,
  input  logic [pvid_pkg::PDATA_W-1:0]  pwdata,
  output logic [pvid_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pvid_pkg::*;

  fmt_e       fmt_q;
  dec_state_t state_q, state_d, step_state;
  logic       step_emit;
  out_item_t  step_result;
  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       in_accept;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & (paddr[2] == REG_FORMAT_SELECT);
  assign prdata    = (paddr[2] == REG_FORMAT_SELECT) ?
                     {{(PDATA_W-2){1'b0}}, fmt_q} : '0;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  pvid_step u_step (
    .fmt_i    (fmt_q),
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (step_state),
    .emit_o   (step_emit),
    .result_o (step_result)
  );

  // Pick the next decoder state: config write clears, a transaction advances
  always_comb begin
    state_d = state_q;
    if (cfg_write) begin
      state_d = DEC_IDLE;
    end else if (in_accept) begin
      state_d = step_state;
    end
  end

  // Hold configuration and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= FMT_RESET;
      state_q <= DEC_IDLE;
    end else begin
      if (cfg_write) begin
        fmt_q <= fmt_e'(pwdata[1:0]);
      end
      state_q <= state_d;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= step_emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && step_emit) begin
      out_data_q <= step_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/pvid_checker.sv
module pvid_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pvid_pkg::out_item_t out_data_o,
  input logic               pready
);
  import pvid_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // A taken result with no new transaction leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result repeated");

  // A result only follows an accepted transaction
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without a transaction");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind prefix_varint_integer_decoder_core pvid_checker u_pvid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
